>>> sv/pbce_pkg.sv
// Package for the pixel byte colour expander: register indexes, item codes,
// the configuration and item structs and the pen-to-colour mapping.
// No dependencies.
package pbce_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_COLOUR_MODE    = 3'd0;
    localparam logic [2:0] REG_MSB_ALTERNATE  = 3'd1;
    localparam logic [2:0] REG_LSB_ALTERNATE  = 3'd2;
    localparam logic [2:0] REG_CHAR_ALTERNATE = 3'd3;
    localparam logic [2:0] REG_FIX_BIAS       = 3'd4;
    localparam logic [2:0] REG_PALETTE_LOW    = 3'd5;
    localparam logic [2:0] REG_PALETTE_HIGH   = 3'd6;

    // Input word mode codes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_DOUBLE = 2'd1;
    localparam logic [1:0] MODE_ATTR   = 2'd2;
    localparam logic [1:0] MODE_IGNORE = 2'd3;

    // Colour mode codes
    localparam logic [1:0] COL_TWO     = 2'd0;
    localparam logic [1:0] COL_FOUR    = 2'd1;
    localparam logic [1:0] COL_SIXTEEN = 2'd2;
    localparam logic [1:0] COL_DIRECT  = 2'd3;

    localparam int CFG_DATA_W = 32;
    localparam int PIX_CNT_W  = 4;

    typedef struct packed {
        logic [1:0]  colour_mode;
        logic        msb_alternate;
        logic        lsb_alternate;
        logic        char_alternate;
        logic [4:0]  fix_bias;
        logic [31:0] palette_low;
        logic [31:0] palette_high;
    } cfg_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] video_byte;
        logic [7:0] side_byte;
    } item_t;

    // Pens 8..15 take the fixed bias, pens 0..7 the palette
    function automatic logic [7:0] pen_colour(input logic [3:0] pen, input cfg_t cfg);
        logic [7:0] colour;
        colour = 8'h00;
        if (pen[3])
        begin
            colour = {cfg.fix_bias, pen[2:0]};
        end
        else
        begin
            case (pen[2:0])
                3'd0:    colour = cfg.palette_low[7:0];
                3'd1:    colour = cfg.palette_low[15:8];
                3'd2:    colour = cfg.palette_low[23:16];
                3'd3:    colour = cfg.palette_low[31:24];
                3'd4:    colour = cfg.palette_high[7:0];
                3'd5:    colour = cfg.palette_high[15:8];
                3'd6:    colour = cfg.palette_high[23:16];
                default: colour = cfg.palette_high[31:24];
            endcase
        end
        return colour;
    endfunction

endpackage

>>> sv/pbce_cfg_regs.sv
// Configuration register file for the pixel byte colour expander.
// Depends on pbce_pkg (register indexes, cfg_t).
module pbce_cfg_regs
    import pbce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_COLOUR_MODE:    cfg_next.colour_mode    = cfg_data[1:0];
                REG_MSB_ALTERNATE:  cfg_next.msb_alternate  = cfg_data[0];
                REG_LSB_ALTERNATE:  cfg_next.lsb_alternate  = cfg_data[0];
                REG_CHAR_ALTERNATE: cfg_next.char_alternate = cfg_data[0];
                REG_FIX_BIAS:       cfg_next.fix_bias       = cfg_data[4:0];
                REG_PALETTE_LOW:    cfg_next.palette_low    = cfg_data[31:0];
                REG_PALETTE_HIGH:   cfg_next.palette_high   = cfg_data[31:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/pbce_pixel_gen.sv
// Pixel colour for one position of the held byte: alternate-bit masking,
// pen extraction per colour mode, attribute pens and palette lookup.
// Depends on pbce_pkg (item_t, cfg_t, pen_colour).
module pbce_pixel_gen
    import pbce_pkg::*;
(
    input  item_t                item,
    input  logic [PIX_CNT_W-1:0] pix_idx,
    input  cfg_t                 cfg,
    output logic [7:0]           colour,
    output logic                 last
);

    logic [7:0] data_m;
    logic [2:0] offs;
    logic [2:0] pos;
    logic [1:0] pos4;
    logic       pos16;
    logic [3:0] pen;

    // Alternate bits pick the pen offset and drop out of the pixel data
    always_comb
    begin
        data_m = item.video_byte;
        offs   = 3'd0;
        if (cfg.msb_alternate)
        begin
            offs[1]   = data_m[7];
            data_m[7] = 1'b0;
        end
        if (cfg.lsb_alternate)
        begin
            offs[2]   = data_m[0];
            data_m[0] = 1'b0;
        end
        if (cfg.char_alternate && item.side_byte[7])
        begin
            offs[1] = 1'b1;
        end
    end

    // Source pixel position: doubled and attribute paths repeat each pixel twice
    assign pos   = (item.mode == MODE_NORMAL) ? pix_idx[2:0] : pix_idx[3:1];
    assign pos4  = pos[2:1];
    assign pos16 = pos[2];

    // Pen and colour
    always_comb
    begin
        pen    = 4'd0;
        colour = 8'h00;
        if (item.mode == MODE_ATTR)
        begin
            pen    = item.video_byte[3'd7 - pos] ? item.side_byte[3:0] : item.side_byte[7:4];
            colour = pen_colour(pen, cfg);
        end
        else
        begin
            case (cfg.colour_mode)
                COL_TWO:
                begin
                    pen    = {1'b0, offs[2:1], data_m[3'd7 - pos]};
                    colour = pen_colour(pen, cfg);
                end
                COL_FOUR:
                begin
                    pen    = {2'b00,
                              data_m[3'd3 - {1'b0, pos4}],
                              data_m[3'd7 - {1'b0, pos4}]};
                    colour = pen_colour(pen, cfg);
                end
                COL_SIXTEEN:
                begin
                    pen    = {data_m[3'd1 - {2'b00, pos16}],
                              data_m[3'd5 - {2'b00, pos16}],
                              data_m[3'd3 - {2'b00, pos16}],
                              data_m[3'd7 - {2'b00, pos16}]};
                    colour = pen_colour(pen, cfg);
                end
                default:
                begin
                    colour = data_m;
                end
            endcase
        end
    end

    // Eight pixels in normal width, sixteen otherwise
    assign last = (item.mode == MODE_NORMAL) ? (pix_idx == 4'd7) : (pix_idx == 4'd15);

endmodule

>>> sv/pixel_byte_colour_expander.sv
// Channel | direction | handshake            | payload
// cfg     | in        | cfg_write            | cfg_index, cfg_data
// in      | in        | in_valid, in_stall   | mode, video_byte, side_byte
// out     | out       | out_valid, out_stall | pixel_colour, last
//
// One pixel word per cycle unless stalled: a byte gives 8 words in normal
// width and 16 in doubled or attribute width, set by the pixel counter.
// The next byte is taken in the cycle its predecessor's last pixel moves to
// the output register, so bytes follow without a gap. Mode 3 bytes are
// taken and dropped. Reset clears the configuration, the pixel counter and
// both valid flags. A stalled output holds its word and the counter waits.
// Depends on pbce_pkg, pbce_cfg_regs and pbce_pixel_gen.
module pixel_byte_colour_expander
    import pbce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [7:0]            video_byte,
    input  logic [7:0]            side_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            pixel_colour,
    output logic                  last
);

    cfg_t                 cfg;
    item_t                hold_reg;
    item_t                hold_next;
    logic                 hold_valid_reg;
    logic                 hold_valid_next;
    logic [PIX_CNT_W-1:0] pix_cnt_reg;
    logic [PIX_CNT_W-1:0] pix_cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           colour_reg;
    logic [7:0]           colour_next;
    logic                 last_reg;
    logic                 last_next;
    logic [7:0]           gen_colour;
    logic                 gen_last;
    logic                 out_free;
    logic                 emit;
    logic                 final_pix;
    logic                 accept;

    pbce_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbce_pixel_gen u_pixel_gen (
        .item    (hold_reg),
        .pix_idx (pix_cnt_reg),
        .cfg     (cfg),
        .colour  (gen_colour),
        .last    (gen_last)
    );

    // Handshake control
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = hold_valid_reg && out_free;
    assign final_pix = emit && gen_last;
    assign in_stall  = hold_valid_reg && !final_pix;
    assign accept    = in_valid && !in_stall;

    // Held byte and pixel counter
    always_comb
    begin
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        pix_cnt_next    = pix_cnt_reg;
        if (final_pix)
        begin
            hold_valid_next = 1'b0;
        end
        if (emit)
        begin
            pix_cnt_next = pix_cnt_reg + 1'b1;
        end
        if (accept && (mode != MODE_IGNORE))
        begin
            hold_next.mode       = mode;
            hold_next.video_byte = video_byte;
            hold_next.side_byte  = side_byte;
            hold_valid_next      = 1'b1;
            pix_cnt_next         = '0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        colour_next    = colour_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            colour_next    = gen_colour;
            last_next      = gen_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pix_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            pix_cnt_reg    <= pix_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        colour_reg <= colour_next;
        last_reg   <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_colour = colour_reg;
    assign last         = last_reg;

endmodule

>>> sv/pbce_checker.sv
// Port-level checks for the pixel byte colour expander, bound to the top level.
// Depends on pixel_byte_colour_expander.
module pbce_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [1:0] mode,
    input logic [7:0] video_byte,
    input logic [7:0] side_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] pixel_colour,
    input logic       last
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_colour) && $stable(last))
        else $error("stalled output word changed");

    // Pixels of one byte follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("gap inside a byte's pixel run");

    // A stalled input means a byte is in work, so a word shows next cycle
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> out_valid)
        else $error("input stalled with no pixel in work");

    // A stalled input word holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(mode) && $stable(video_byte)
                                 && $stable(side_byte))
        else $error("stalled input word changed");

endmodule

bind pixel_byte_colour_expander pbce_checker u_pbce_checker (.*);

>>> verif/pixel_byte_colour_expander_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pixel_byte_colour_expander: sends video bytes under
// a series of register settings, predicts every pixel word and checks each one out.
// Depends on pbce_pkg and the expander RTL; needs no files or arguments.
module pixel_byte_colour_expander_test;
    import pbce_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 24;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 45;
    localparam int HOLD_WORDS      = 16;

    // Local copy of the register file used for prediction
    typedef struct {
        logic [1:0]  colour_mode;
        logic        msb_alt;
        logic        lsb_alt;
        logic        char_alt;
        logic [4:0]  bias;
        logic [31:0] pal_low;
        logic [31:0] pal_high;
    } pen_setup_t;

    typedef struct packed {
        logic [7:0] colour;
        logic       last;
    } pixel_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [2:0]            cfg_index = REG_COLOUR_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode = MODE_NORMAL;
    logic [7:0]            video_byte = 8'h00;
    logic [7:0]            side_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            pixel_colour;
    logic                  last;

    pen_setup_t live_regs = '{2'b00, 1'b0, 1'b0, 1'b0, 5'd0, 32'd0, 32'd0};
    pixel_t     pixels_due[$];

    int  errors = 0;
    int  words_sent = 0;
    int  pixels_checked = 0;
    int  settings_loaded = 0;
    int  quiet_cycles = 0;
    int  sender_gap_pct = 0;
    int  receiver_stall_pct = 0;
    bit  hold_request = 1'b0;

    pixel_byte_colour_expander dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .video_byte   (video_byte),
        .side_byte    (side_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_colour (pixel_colour),
        .last         (last)
    );

    initial
    begin
        forever #HALF_PERIOD clk = ~clk;
    end

    // Pens 8..15 use the fixed bias, pens 0..7 pick a palette byte
    function automatic logic [7:0] colour_of_pen(input logic [3:0] pen);
        logic [63:0] palette;
        palette = {live_regs.pal_high, live_regs.pal_low};
        if (pen[3])
            return {live_regs.bias, pen[2:0]};
        return palette[pen[2:0] * 8 +: 8];
    endfunction

    // Queue one colour reps times; the final word of the byte carries last
    function automatic int queue_run(input logic [7:0] colour, input int reps,
                                     input int done, input int total);
        pixel_t word;
        for (int r = 0; r < reps; r++)
        begin
            word.colour = colour;
            word.last   = (done == total - 1);
            pixels_due.push_back(word);
            done++;
        end
        return done;
    endfunction

    // Expected pixel words for one accepted byte
    function automatic void expand_word(input logic [1:0] m, input logic [7:0] d,
                                        input logic [7:0] s);
        logic [7:0] bits;
        logic [2:0] offs;
        logic [3:0] pen;
        int         scale;
        int         done;
        bits  = d;
        offs  = 3'd0;
        done  = 0;
        scale = (m == MODE_NORMAL) ? 1 : 2;
        if (m == MODE_ATTR)
        begin
            // attribute path ignores colour mode and alternate bits
            for (int p = 0; p < 8; p++)
                done = queue_run(bits[7-p] ? colour_of_pen(s[3:0]) : colour_of_pen(s[7:4]),
                                 2, done, 16);
        end
        else if (m != MODE_IGNORE)
        begin
            // alternate bits steer the pen offset and are masked from the data
            if (live_regs.msb_alt)
            begin
                if (bits[7])
                    offs[1] = 1'b1;
                bits[7] = 1'b0;
            end
            if (live_regs.lsb_alt)
            begin
                if (bits[0])
                    offs[2] = 1'b1;
                bits[0] = 1'b0;
            end
            case (live_regs.colour_mode)
                COL_TWO:
                begin
                    if (live_regs.char_alt && s[7])
                        offs[1] = 1'b1;
                    for (int p = 0; p < 8; p++)
                    begin
                        pen  = {1'b0, offs | {2'b00, bits[7-p]}};
                        done = queue_run(colour_of_pen(pen), scale, done, 8 * scale);
                    end
                end
                COL_FOUR:
                begin
                    for (int p = 0; p < 4; p++)
                    begin
                        pen  = {2'b00, bits[3-p], bits[7-p]};
                        done = queue_run(colour_of_pen(pen), 2 * scale, done, 8 * scale);
                    end
                end
                COL_SIXTEEN:
                begin
                    for (int p = 0; p < 2; p++)
                    begin
                        pen  = {bits[1-p], bits[5-p], bits[3-p], bits[7-p]};
                        done = queue_run(colour_of_pen(pen), 4 * scale, done, 8 * scale);
                    end
                end
                COL_DIRECT:
                begin
                    done = queue_run(bits, 8 * scale, done, 8 * scale);
                end
            endcase
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_idle_length();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Extremes of a register field come up often
    function automatic logic [31:0] pick_field(input logic [31:0] top);
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return top;
            default: return $urandom & top;
        endcase
    endfunction

    // One register write, mirrored into the local copy
    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (index)
            REG_COLOUR_MODE:    live_regs.colour_mode = value[1:0];
            REG_MSB_ALTERNATE:  live_regs.msb_alt     = value[0];
            REG_LSB_ALTERNATE:  live_regs.lsb_alt     = value[0];
            REG_CHAR_ALTERNATE: live_regs.char_alt    = value[0];
            REG_FIX_BIAS:       live_regs.bias        = value[4:0];
            REG_PALETTE_LOW:    live_regs.pal_low     = value;
            REG_PALETTE_HIGH:   live_regs.pal_high    = value;
            default: ;
        endcase
    endtask

    task automatic load_regs(input logic [1:0] colours, input logic msb, input logic lsb,
                             input logic chr, input logic [4:0] bias,
                             input logic [31:0] pal_low, input logic [31:0] pal_high);
        write_reg(REG_COLOUR_MODE, {30'd0, colours});
        write_reg(REG_MSB_ALTERNATE, {31'd0, msb});
        write_reg(REG_LSB_ALTERNATE, {31'd0, lsb});
        write_reg(REG_CHAR_ALTERNATE, {31'd0, chr});
        write_reg(REG_FIX_BIAS, {27'd0, bias});
        write_reg(REG_PALETTE_LOW, pal_low);
        write_reg(REG_PALETTE_HIGH, pal_high);
        settings_loaded++;
    endtask

    // Offer one byte, after an optional gap, and wait until it is taken
    task automatic send_word(input logic [1:0] m, input logic [7:0] d, input logic [7:0] s);
        int gap;
        gap = 0;
        if (sender_gap_pct != 0 && $urandom_range(0, 99) < sender_gap_pct)
            gap = pick_idle_length();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        video_byte <= d;
        side_byte  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_random_word();
        logic [1:0] m;
        m = ($urandom_range(0, 11) == 0) ? MODE_IGNORE : 2'($urandom_range(0, 2));
        send_word(m, 8'($urandom), 8'($urandom));
    endtask

    // Drop valid, wait for every pixel due, then let a dropped byte finish
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers at reset: palette and bias all zero
    task automatic test_reset_defaults();
        send_word(MODE_NORMAL, 8'hFF, 8'hFF);
        send_word(MODE_ATTR, 8'h0F, 8'hF0);
        settle_block();
    endtask

    // Two colours: alternate offsets from data and side bytes, then plain pens
    task automatic test_two_colour();
        load_regs(COL_TWO, 1'b1, 1'b1, 1'b1, 5'd31, 32'hD4C3B2A1, 32'h98877665);
        send_word(MODE_NORMAL, 8'h81, 8'h80);
        send_word(MODE_DOUBLE, 8'h7E, 8'h7F);
        send_word(MODE_NORMAL, 8'h00, 8'h00);
        settle_block();
        load_regs(COL_TWO, 1'b0, 1'b0, 1'b0, 5'd31, 32'hD4C3B2A1, 32'h98877665);
        send_word(MODE_DOUBLE, 8'hA5, 8'h80);
        settle_block();
    endtask

    // Four and sixteen colours, with masking still applied
    task automatic test_four_sixteen();
        load_regs(COL_FOUR, 1'b0, 1'b1, 1'b0, 5'd0, 32'hFFFFFFFF, 32'h00000000);
        send_word(MODE_NORMAL, 8'hA5, 8'h00);
        send_word(MODE_DOUBLE, 8'h5B, 8'hFF);
        settle_block();
        load_regs(COL_SIXTEEN, 1'b1, 1'b0, 1'b0, 5'd31, 32'h3C2D1E0F, 32'h78695A4B);
        send_word(MODE_NORMAL, 8'hFF, 8'h00);
        send_word(MODE_DOUBLE, 8'h3C, 8'h80);
        send_word(MODE_NORMAL, 8'h0F, 8'hFF);
        settle_block();
    endtask

    // Direct colour passes the masked byte straight through
    task automatic test_direct_colour();
        load_regs(COL_DIRECT, 1'b1, 1'b1, 1'b1, 5'd21, 32'h12345678, 32'h9ABCDEF0);
        send_word(MODE_NORMAL, 8'hFF, 8'h80);
        send_word(MODE_DOUBLE, 8'h81, 8'h00);
        settle_block();
        load_regs(COL_DIRECT, 1'b0, 1'b0, 1'b0, 5'd21, 32'h12345678, 32'h9ABCDEF0);
        send_word(MODE_NORMAL, 8'h80, 8'h7F);
        settle_block();
    endtask

    // Attribute path under settings it must ignore
    task automatic test_attribute();
        load_regs(COL_DIRECT, 1'b1, 1'b1, 1'b1, 5'd31, 32'hD4C3B2A1, 32'h98877665);
        send_word(MODE_ATTR, 8'hAA, 8'hF0);
        send_word(MODE_ATTR, 8'h55, 8'h8F);
        send_word(MODE_ATTR, 8'hFF, 8'h07);
        send_word(MODE_ATTR, 8'h00, 8'h7E);
        settle_block();
    endtask

    // Unused mode gives nothing, even between real bytes
    task automatic test_ignored_mode();
        send_word(MODE_IGNORE, 8'hFF, 8'hFF);
        send_word(MODE_NORMAL, 8'h96, 8'h00);
        send_word(MODE_IGNORE, 8'h00, 8'h00);
        send_word(MODE_DOUBLE, 8'h69, 8'hFF);
        settle_block();
    endtask

    // Random bytes under a run of random settings and idling levels
    task automatic test_random_settings();
        logic [4:0] bias;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            bias = (phase == 1) ? 5'd31 : 5'(pick_field(32'd31));
            load_regs(2'(phase % 4), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), bias,
                      pick_field(32'hFFFFFFFF), pick_field(32'hFFFFFFFF));
            case (phase % 3)
                0:
                begin
                    sender_gap_pct     = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_gap_pct     = 20;
                    receiver_stall_pct = 20;
                end
                default:
                begin
                    sender_gap_pct     = 50;
                    receiver_stall_pct = 60;
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_random_word();
            settle_block();
        end
    endtask

    // Receiver holds off for a long stretch while bytes keep coming
    task automatic test_output_hold_off();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        hold_request       = 1'b1;
        for (int n = 0; n < HOLD_WORDS; n++)
            send_word(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom));
        settle_block();
    endtask

    // Receiver: random stalls, or the long hold-off when asked
    initial
    begin : receiver
        int len;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (receiver_stall_pct != 0 && $urandom_range(0, 99) < receiver_stall_pct)
            begin
                len = pick_idle_length();
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // Check each pixel word taken, then predict for each byte taken
    always @(posedge clk)
    begin : pixel_checker
        pixel_t want;
        if (out_valid && !out_stall)
        begin
            pixels_checked++;
            if (pixels_due.size() == 0)
            begin
                $error("unexpected pixel word: pixel_colour %02h last %0b", pixel_colour, last);
                errors++;
            end
            else
            begin
                want = pixels_due.pop_front();
                if (pixel_colour !== want.colour)
                begin
                    $error("pixel_colour: expected %02h, got %02h", want.colour, pixel_colour);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    errors++;
                end
            end
        end
        if (in_valid && !in_stall)
            expand_word(mode, video_byte, side_byte);
    end

    // Watchdog: ends the run if nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $error("timeout: nothing moved for %0d cycles, %0d pixel words still due",
                   quiet_cycles, pixels_due.size());
            $display("pixel_byte_colour_expander_test NOT OK");
            $finish;
        end
    end

    initial
    begin : sequencer
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        sender_gap_pct     = 30;
        receiver_stall_pct = 30;
        test_reset_defaults();
        test_two_colour();
        test_four_sixteen();
        test_direct_colour();
        test_attribute();
        test_ignored_mode();
        test_random_settings();
        test_output_hold_off();
        settle_block();
        $display("Covered %0d bytes in all input and colour modes under %0d register settings,",
                 words_sent, settings_loaded);
        $display("with random idling and a %0d-cycle output hold-off; %0d pixel words compared.",
                 HOLD_CYCLES, pixels_checked);
        if (errors == 0 && pixels_due.size() == 0)
            $display("pixel_byte_colour_expander_test OK");
        else
            $display("pixel_byte_colour_expander_test NOT OK");
        $finish;
    end

endmodule
